// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL files. They compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RTT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RTT_ASSERT(label, clk, rst_n, prop)
`define RTT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/rtt_pkg.sv =====
// ---------------------------------------------------------------------------
// rtt_pkg
// Types and codes shared by the region translation table modules.
// ---------------------------------------------------------------------------
package rtt_pkg;

  localparam int unsigned DEV_W    = 3;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned LEN_W    = 48;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // Region lengths must be a multiple of 64 KiB.
  localparam int unsigned ALIGN_BITS = 16;

  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSLATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALIGN    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd6;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  device;
    logic [ADDR_W-1:0] base_addr;
    logic [LEN_W-1:0]  length_bytes;
    logic [ADDR_W-1:0] mapped_addr;
    logic [LEN_W-1:0]  buffer_offset;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_addr;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== rtl/core/rtt_ctrl.sv =====
// ---------------------------------------------------------------------------
// rtt_ctrl
// Sequencer: captures a word, then commits it once the result register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rtt_pkg::ctrl_cmd_t cmd_o
);
  import rtt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        room;

  assign room = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (room) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.commit = room;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RTT_ASSERT(a_accept_to_exec, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q == S_EXEC)
  `RTT_ASSERT(a_commit_shows_result, clk_i, rst_ni, cmd_o.commit |=> out_valid_o)
  `RTT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.commit && out_valid_q && !out_ready_i)
  `RTT_ASSERT(a_result_after_commit, clk_i, rst_ni, $rose(out_valid_o) |-> $past(cmd_o.commit))

endmodule

// ===== rtl/core/rtt_datapath.sv =====
// ---------------------------------------------------------------------------
// rtt_datapath
// Region slots (newest first), parallel containment compare, result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rtt_datapath #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned DEVICES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtt_pkg::ctrl_cmd_t cmd_i,
  input  rtt_pkg::req_t      in_data_i,
  output rtt_pkg::rsp_t      out_data_o
);
  import rtt_pkg::*;

  typedef struct packed {
    logic [DEV_W-1:0]  device;
    logic [ADDR_W-1:0] base_addr;
    logic [LEN_W-1:0]  length_bytes;
    logic [ADDR_W-1:0] mapped_addr;
  } slot_t;

  localparam logic [DEV_W:0] DEV_LIMIT = (DEV_W+1)'(DEVICES);

  logic [ENTRIES-1:0] valid_q;
  slot_t              slot_q [ENTRIES];
  req_t               req_q;
  logic [ENTRIES-1:0] match_q, match_d;
  rsp_t               rsp_q, rsp_d;

  logic               in_dev_ok;
  logic [ADDR_W:0]    query_end;
  logic [ENTRIES-1:0] hit_oh, ge_mask;
  logic               hit;
  slot_t              hit_slot;
  logic               dev_ok, aligned, over_range;
  logic               ins_ok, rem_ok;
  slot_t              new_slot;

  // ---- capture: compare the query against every slot ----
  assign in_dev_ok = {1'b0, in_data_i.device} < DEV_LIMIT;
  assign query_end = {1'b0, in_data_i.base_addr} + (ADDR_W+1)'(in_data_i.length_bytes);

  always_comb begin
    logic [ADDR_W:0] slot_end;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_end   = {1'b0, slot_q[i].base_addr} + (ADDR_W+1)'(slot_q[i].length_bytes);
      match_d[i] = in_dev_ok && valid_q[i] &&
                   (slot_q[i].device == in_data_i.device) &&
                   (slot_q[i].base_addr <= in_data_i.base_addr) &&
                   (slot_end >= query_end);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= in_data_i;
      match_q <= match_d;
    end
  end

  // ---- execute: pick the newest hit and form the result ----
  assign hit_oh  = match_q & (~match_q + ENTRIES'(1));
  assign hit     = |match_q;
  assign ge_mask = ~(hit_oh - ENTRIES'(1));

  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_slot = hit_slot | (slot_q[i] & {$bits(slot_t){hit_oh[i]}});
    end
  end

  assign dev_ok     = {1'b0, req_q.device} < DEV_LIMIT;
  assign aligned    = req_q.length_bytes[ALIGN_BITS-1:0] == '0;
  assign over_range = ({1'b0, req_q.length_bytes} + {1'b0, req_q.buffer_offset}) >
                      {1'b0, hit_slot.length_bytes};

  always_comb begin
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    rsp_d  = '{status: ST_NOTFOUND, result_addr: '0};
    unique case (req_q.kind)
      KIND_INSERT: begin
        if (!aligned) begin
          rsp_d.status = ST_ALIGN;
        end else if (!dev_ok) begin
          rsp_d.status = ST_NOTFOUND;
        end else if (valid_q[ENTRIES-1]) begin
          rsp_d.status = ST_FULL;
        end else begin
          ins_ok            = 1'b1;
          rsp_d.status      = ST_OK;
          rsp_d.result_addr = req_q.mapped_addr;
        end
      end
      KIND_REMOVE: begin
        if (!hit) begin
          rsp_d.status = ST_NOTFOUND;
        end else if (hit_slot.length_bytes != req_q.length_bytes) begin
          rsp_d.status = ST_MISMATCH;
        end else begin
          rem_ok       = 1'b1;
          rsp_d.status = ST_OK;
        end
      end
      KIND_TRANSLATE: begin
        if (!hit) begin
          rsp_d.status      = ST_MISS;
          rsp_d.result_addr = req_q.base_addr + ADDR_W'(req_q.buffer_offset);
        end else if (over_range) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.status      = ST_OK;
          rsp_d.result_addr = hit_slot.mapped_addr + ADDR_W'(req_q.buffer_offset);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

  // ---- slot update: insert shifts all down, remove closes the gap ----
  assign new_slot = '{device:       req_q.device,
                      base_addr:    req_q.base_addr,
                      length_bytes: req_q.length_bytes,
                      mapped_addr:  req_q.mapped_addr};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
    slot_t up_slot, dn_slot;
    logic  up_valid, dn_valid;

    if (i == 0) begin : g_head
      assign up_slot  = new_slot;
      assign up_valid = 1'b1;
    end else begin : g_body
      assign up_slot  = slot_q[i-1];
      assign up_valid = valid_q[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign dn_slot  = slot_q[i];
      assign dn_valid = 1'b0;
    end else begin : g_inner
      assign dn_slot  = slot_q[i+1];
      assign dn_valid = valid_q[i+1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (cmd_i.commit && ins_ok) begin
        valid_q[i] <= up_valid;
      end else if (cmd_i.commit && rem_ok && ge_mask[i]) begin
        valid_q[i] <= dn_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.commit && ins_ok) begin
        slot_q[i] <= up_slot;
      end else if (cmd_i.commit && rem_ok && ge_mask[i]) begin
        slot_q[i] <= dn_slot;
      end
    end
  end

  `RTT_NEVER(a_valid_prefix, clk_i, rst_ni, (valid_q & (valid_q + ENTRIES'(1))) != '0)
  `RTT_ASSERT(a_insert_grows, clk_i, rst_ni, cmd_i.commit && ins_ok |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
  `RTT_ASSERT(a_remove_shrinks, clk_i, rst_ni, cmd_i.commit && rem_ok |=> $countones(valid_q) + 1 == $past($countones(valid_q)))

endmodule

// ===== rtl/core/region_translation_table.sv =====
// ---------------------------------------------------------------------------
// region_translation_table
// Per-device table of address regions with insert, remove and translate.
// ---------------------------------------------------------------------------
// In the accept cycle (S_IDLE) the query is compared against all ENTRIES
// slots at once and the hit vector is registered; in S_EXEC, once the
// output register is free, the newest hit is selected, the result is
// written to the output register and the slot list is updated. A new word
// is accepted only after the last one has committed; in_ready_o stays low
// while a word waits in S_EXEC for the output register to free up.
// Slots are kept newest first; no clearing pass runs after reset.
// ---------------------------------------------------------------------------
module region_translation_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned DEVICES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rtt_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rtt_pkg::rsp_t out_data_o
);
  import rtt_pkg::*;

  ctrl_cmd_t cmd;

  rtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rtt_datapath #(
    .ENTRIES (ENTRIES),
    .DEVICES (DEVICES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
